[rtl/core/sfck_pkg.sv]
// ============================================================================
// sfck_pkg
// Shared types, codes and helpers for the space-filling-curve key generator.
// ============================================================================
`default_nettype none

package sfck_pkg;

    // Field widths
    localparam int COORD_BITS = 21;
    localparam int TAG_BITS   = 16;
    localparam int KEY_BITS   = 63;
    localparam int MAX_ORDER  = 16;
    localparam int ORD_BITS   = 5;
    localparam int HKEY_BITS  = 2 * MAX_ORDER;

    // Configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_MODE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_ORDER = CFG_IDX_BITS'(1);

    localparam logic [ORD_BITS-1:0] ORDER_RESET = ORD_BITS'(MAX_ORDER);

    // Curve selection
    typedef enum logic [1:0] {
        MODE_HILBERT_2D = 2'd0,
        MODE_HILBERT_3D = 2'd1,
        MODE_MORTON_2D  = 2'd2,
        MODE_MORTON_3D  = 2'd3
    } mode_t;

    // Hilbert walk orientation: swap x/y, then complement both
    typedef struct packed {
        logic swap;
        logic inv;
    } hs_t;

    // Clamp the order register to 1..MAX_ORDER
    function automatic logic [ORD_BITS-1:0] eff_order(input logic [ORD_BITS-1:0] ord);
        logic [ORD_BITS-1:0] res;
        if (ord == '0) begin
            res = ORD_BITS'(1);
        end
        else if (ord > ORD_BITS'(MAX_ORDER)) begin
            res = ORD_BITS'(MAX_ORDER);
        end
        else begin
            res = ord;
        end
        return res;
    endfunction

    // Low-bit mask of a valid (1..16) order
    function automatic logic [MAX_ORDER-1:0] order_mask(input logic [ORD_BITS-1:0] ord);
        logic [MAX_ORDER:0] m;
        m = ((MAX_ORDER+1)'(1) << ord) - (MAX_ORDER+1)'(1);
        return m[MAX_ORDER-1:0];
    endfunction

endpackage : sfck_pkg

`default_nettype wire

[rtl/core/space_filling_curve_key.sv]
// ============================================================================
// space_filling_curve_key
// Grid point to space-filling-curve key: 2D Hilbert, simplified 3D Hilbert,
// 2D Morton or 3D Morton, with a tag carried alongside.
// Pipeline: an accepted item passes the input, mid and result regs in order,
// and out_valid rises when it reaches the result regs. Throughput: one item
// per cycle unless out_ready low stalls a full pipeline; the Hilbert walk is
// split into two eight-level halves, one per pipeline stage, which sets the depth.
// Reset: pipeline emptied, curve_mode = Hilbert 2D, curve order = 16.
// ============================================================================
`default_nettype none

module space_filling_curve_key
    import sfck_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    // input items
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [COORD_BITS-1:0]    coord_x,
    input  wire logic [COORD_BITS-1:0]    coord_y,
    input  wire logic [COORD_BITS-1:0]    coord_z,
    input  wire logic [TAG_BITS-1:0]      point_tag,
    // result items
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [KEY_BITS-1:0]           curve_key,
    output logic [TAG_BITS-1:0]           tag_out
);

    // Configuration registers
    mode_t               curve_mode_reg;
    logic [ORD_BITS-1:0] curve_order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg  <= MODE_HILBERT_2D;
            curve_order_reg <= ORDER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CURVE_MODE:  curve_mode_reg  <= mode_t'(cfg_data[1:0]);
                CFG_CURVE_ORDER: curve_order_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic [ORD_BITS-1:0]  ord;
    logic [MAX_ORDER-1:0] omask;

    assign ord   = eff_order(curve_order_reg);
    assign omask = order_mask(ord);

    // Pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s2_ready;
    logic s1_ready;

    assign out_load = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || out_load;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: input register
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [COORD_BITS-1:0] s1_z_reg;
    logic [TAG_BITS-1:0]   s1_tag_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_x_reg   <= coord_x;
            s1_y_reg   <= coord_y;
            s1_z_reg   <= coord_z;
            s1_tag_reg <= point_tag;
        end
    end

    // Upper half of the Hilbert walk (bits 15..8)
    logic [MAX_ORDER-1:0] s1_hx;
    logic [MAX_ORDER-1:0] s1_hy;
    logic [15:0]          hkey_hi_next;
    hs_t                  hs_mid_next;

    assign s1_hx = s1_x_reg[MAX_ORDER-1:0] & omask;
    assign s1_hy = s1_y_reg[MAX_ORDER-1:0] & omask;

    sfck_hilbert_oct u_hil_hi (
        .x_bits (s1_hx[15:8]),
        .y_bits (s1_hy[15:8]),
        .ord    (ord),
        .upper  (1'b1),
        .hs_in  ('0),
        .digits (hkey_hi_next),
        .hs_out (hs_mid_next)
    );

    // Stage 2: mid register
    logic [COORD_BITS-1:0] s2_x_reg;
    logic [COORD_BITS-1:0] s2_y_reg;
    logic [COORD_BITS-1:0] s2_z_reg;
    logic [TAG_BITS-1:0]   s2_tag_reg;
    logic [15:0]           s2_hkey_hi_reg;
    hs_t                   s2_hs_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_x_reg       <= s1_x_reg;
            s2_y_reg       <= s1_y_reg;
            s2_z_reg       <= s1_z_reg;
            s2_tag_reg     <= s1_tag_reg;
            s2_hkey_hi_reg <= hkey_hi_next;
            s2_hs_reg      <= hs_mid_next;
        end
    end

    // Lower half of the Hilbert walk (bits 7..0)
    logic [15:0]          hkey_lo;
    hs_t                  hs_end;
    logic [HKEY_BITS-1:0] hkey;
    logic [MAX_ORDER-1:0] s2_hz;
    logic [KEY_BITS-1:0]  z_part;
    logic [KEY_BITS-1:0]  morton_key;
    logic [KEY_BITS-1:0]  curve_key_next;

    sfck_hilbert_oct u_hil_lo (
        .x_bits (s2_x_reg[7:0] & omask[7:0]),
        .y_bits (s2_y_reg[7:0] & omask[7:0]),
        .ord    (ord),
        .upper  (1'b0),
        .hs_in  (s2_hs_reg),
        .digits (hkey_lo),
        .hs_out (hs_end)
    );

    assign hkey   = {s2_hkey_hi_reg, hkey_lo};
    assign s2_hz  = s2_z_reg[MAX_ORDER-1:0] & omask;
    // z sits above the 2*order Hilbert bits, so the add is an OR
    assign z_part = KEY_BITS'(s2_hz) << {ord, 1'b0};

    sfck_morton u_morton (
        .x       (s2_x_reg),
        .y       (s2_y_reg),
        .z       (s2_z_reg),
        .three_d (curve_mode_reg == MODE_MORTON_3D),
        .key     (morton_key)
    );

    // Curve select
    always_comb
    begin
        case (curve_mode_reg)
            MODE_HILBERT_2D: curve_key_next = KEY_BITS'(hkey);
            MODE_HILBERT_3D: curve_key_next = KEY_BITS'(hkey) | z_part;
            default:         curve_key_next = morton_key;
        endcase
    end

    // Stage 3: result register
    logic [KEY_BITS-1:0] curve_key_reg;
    logic [TAG_BITS-1:0] tag_out_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_load)
        begin
            curve_key_reg <= curve_key_next;
            tag_out_reg   <= s2_tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign curve_key = curve_key_reg;
    assign tag_out   = tag_out_reg;

    // Checks
    a_hil2d_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && curve_mode_reg == MODE_HILBERT_2D
        |-> (curve_key >> {ord, 1'b0}) == '0)
        else $error("2D Hilbert key exceeds 2*order bits");

    a_mor2d_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && curve_mode_reg == MODE_MORTON_2D
        |-> curve_key[KEY_BITS-1:2*COORD_BITS] == '0)
        else $error("2D Morton key exceeds 42 bits");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_load |=> s2_valid_reg)
        else $error("mid stage item lost while output stalled");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("input stalled with a free pipeline slot");

endmodule : space_filling_curve_key

`default_nettype wire

[rtl/core/sfck_hilbert_oct.sv]
// ============================================================================
// sfck_hilbert_oct
// Eight levels of the 2D Hilbert walk, top bit first. Levels at or above the
// configured order emit a zero digit and leave the orientation untouched.
// ============================================================================
`default_nettype none

module sfck_hilbert_oct
    import sfck_pkg::*;
(
    input  wire logic [7:0]          x_bits,
    input  wire logic [7:0]          y_bits,
    input  wire logic [ORD_BITS-1:0] ord,
    input  wire logic                upper,
    input  wire hs_t                 hs_in,
    output logic [15:0]              digits,
    output hs_t                      hs_out
);

    // Walk from bit 7 down to bit 0 of this octet
    always_comb
    begin
        hs_t        st;
        logic       a;
        logic       b;
        logic       active;
        logic [3:0] lvl;
        st     = hs_in;
        digits = '0;
        for (int j = 7; j >= 0; j--)
        begin
            lvl    = {upper, 3'(j)};
            active = ({1'b0, lvl} < ord);
            // current x/y bits under the accumulated orientation
            a = (st.swap ? y_bits[j] : x_bits[j]) ^ st.inv;
            b = (st.swap ? x_bits[j] : y_bits[j]) ^ st.inv;
            if (active)
            begin
                digits[2*j+1] = a;
                digits[2*j]   = a ^ b;
                if (!b)
                begin
                    st.inv  = st.inv ^ a;
                    st.swap = ~st.swap;
                end
            end
        end
        hs_out = st;
    end

endmodule : sfck_hilbert_oct

`default_nettype wire

[rtl/core/sfck_morton.sv]
// ============================================================================
// sfck_morton
// Morton (Z-order) bit interleave of the grid coordinates, 2D or 3D.
// ============================================================================
`default_nettype none

module sfck_morton
    import sfck_pkg::*;
(
    input  wire logic [COORD_BITS-1:0] x,
    input  wire logic [COORD_BITS-1:0] y,
    input  wire logic [COORD_BITS-1:0] z,
    input  wire logic                  three_d,
    output logic [KEY_BITS-1:0]        key
);

    logic [2*COORD_BITS-1:0] key2;
    logic [3*COORD_BITS-1:0] key3;

    // Interleave: 2D puts x at even bits, 3D places x, y, z every third bit
    always_comb
    begin
        key2 = '0;
        key3 = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            key2[2*i]   = x[i];
            key2[2*i+1] = y[i];
            key3[3*i]   = x[i];
            key3[3*i+1] = y[i];
            key3[3*i+2] = z[i];
        end
    end

    assign key = three_d ? KEY_BITS'(key3) : KEY_BITS'(key2);

endmodule : sfck_morton

`default_nettype wire
